@@ rtl/core/page_framebuffer_blitter_macros.svh @@
// Assertion macros shared by the checker of the frame buffer blitter.
`ifndef PAGE_FRAMEBUFFER_BLITTER_MACROS_SVH
`define PAGE_FRAMEBUFFER_BLITTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfb check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfb check failed");

`endif

@@ rtl/core/pfb_pkg.sv @@
package pfb_pkg;

	localparam int MAX_WIDTH   = 128;
	localparam int MAX_PAGES   = 8;
	localparam int STORE_BYTES = MAX_WIDTH * MAX_PAGES;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] CMD_CLEAR = 3'd0;
	localparam logic [2:0] CMD_PIXEL = 3'd1;
	localparam logic [2:0] CMD_BLIT  = 3'd2;
	localparam logic [2:0] CMD_SRC   = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam logic [1:0] PIX_CLEAR  = 2'd0;
	localparam logic [1:0] PIX_SET    = 2'd1;
	localparam logic [1:0] PIX_INVERT = 2'd2;
	localparam logic [1:0] PIX_BAD    = 2'd3;

	localparam logic [1:0] CFG_WIDTH = 2'd0;
	localparam logic [1:0] CFG_PAGES = 2'd1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_READ,
		OP_MERGE
	} op_kind_t;

	// One decoded command handed from the front end to the store sequencer.
	typedef struct packed {
		op_kind_t            kind;
		logic [ADDR_W-1:0]   addr0;
		logic [ADDR_W-1:0]   addr1;
		logic                en0;
		logic                en1;
		logic [7:0]          keep0;
		logic [7:0]          bits0;
		logic [7:0]          keep1;
		logic [7:0]          bits1;
		logic                flip;
		logic                err;
		logic                done;
	} op_t;

	typedef struct packed {
		logic [7:0] width;
		logic [3:0] pages;
	} cfg_t;

	typedef struct packed {
		logic initializing;
	} back_status_t;

endpackage

@@ rtl/core/pfb_front.sv @@
module pfb_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [2:0]      opcode,
	input  logic [6:0]      pos_x,
	input  logic [5:0]      pos_y,
	input  logic [1:0]      pixel_mode,
	input  logic [5:0]      src_row,
	input  logic [7:0]      rect_width,
	input  logic [6:0]      rect_height,
	input  logic [7:0]      src_byte,
	input  logic [9:0]      read_index,
	input  pfb_pkg::cfg_t   cfg,
	output pfb_pkg::op_t    op
);

	logic       active_q;
	logic [3:0] dest_page_q;
	logic [2:0] dest_bit_q;
	logic [2:0] src_bit_q;
	logic [7:0] col_cnt_q;
	logic [6:0] rows_left_q;
	logic [6:0] origin_q;
	logic [7:0] blit_cols_q;

	logic [7:0]  w;
	logic [3:0]  pages;
	logic [6:0]  rows;
	logic [3:0]  avail;
	logic [3:0]  n;
	logic [7:0]  nmask;
	logic [7:0]  block;
	logic [8:0]  col;
	logic [15:0] low_wide;
	logic [15:0] bits_wide;
	logic [3:0]  room;
	logic        spill_en;
	logic [3:0]  spill;
	logic [4:0]  page1;
	logic        ok0;
	logic        ok1;
	logic [12:0] idx0;
	logic [12:0] idx1;
	logic [7:0]  cnt_next;
	logic        row_end;
	logic [3:0]  bit_sum;
	logic [11:0] pix_idx;
	logic [11:0] store_used;
	logic        pix_bad;
	logic        blit_bad;
	logic [7:0]  pix_bit;

	always_comb begin
		w     = (cfg.width > 8'(pfb_pkg::MAX_WIDTH)) ? 8'(pfb_pkg::MAX_WIDTH) : cfg.width;
		pages = (cfg.pages > 4'(pfb_pkg::MAX_PAGES)) ? 4'(pfb_pkg::MAX_PAGES) : cfg.pages;
		rows  = {pages[3:0], 3'b000};

		// Blit source byte: rows still needed from this source page.
		avail    = 4'd8 - {1'b0, src_bit_q};
		n        = ({3'b000, avail} > rows_left_q) ? rows_left_q[3:0] : avail;
		nmask    = 8'((9'd1 << n) - 9'd1);
		block    = (src_byte >> src_bit_q) & nmask;
		col      = {2'b00, origin_q} + {1'b0, col_cnt_q};
		low_wide = {8'h00, nmask} << dest_bit_q;
		bits_wide = {8'h00, block} << dest_bit_q;
		room     = 4'd8 - {1'b0, dest_bit_q};
		spill_en = n > room;
		spill    = n - room;
		page1    = {1'b0, dest_page_q} + 5'd1;
		ok0      = (col < {1'b0, w}) && (dest_page_q < pages);
		ok1      = (col < {1'b0, w}) && (page1 < {1'b0, pages});
		idx0     = {4'h0, col} + 13'(dest_page_q * w);
		idx1     = {4'h0, col} + 13'(page1[3:0] * w);
		cnt_next = col_cnt_q + 8'd1;
		row_end  = cnt_next >= blit_cols_q;
		bit_sum  = {1'b0, dest_bit_q} + n;

		pix_bad  = ({1'b0, pos_x} >= w) || ({1'b0, pos_y} >= rows) ||
			(pixel_mode == pfb_pkg::PIX_BAD);
		pix_idx  = {5'h00, pos_x} + 12'(pos_y[5:3] * w);
		pix_bit  = 8'(9'd1 << pos_y[2:0]);
		blit_bad = (rect_width == 8'd0) || (rect_height == 7'd0) ||
			(({2'b00, pos_x} + {1'b0, rect_width}) > {1'b0, w}) ||
			(({2'b00, pos_y} + {1'b0, rect_height}) > {1'b0, rows});
		store_used = 12'(w * pages);

		op       = '0;
		op.kind  = pfb_pkg::OP_NONE;
		unique case (opcode)
			pfb_pkg::CMD_CLEAR: begin
				op.kind = pfb_pkg::OP_CLEAR;
			end
			pfb_pkg::CMD_PIXEL: begin
				op.err   = pix_bad;
				op.kind  = pix_bad ? pfb_pkg::OP_NONE : pfb_pkg::OP_MERGE;
				op.addr0 = pix_idx[pfb_pkg::ADDR_W-1:0];
				op.en0   = !pix_bad;
				op.keep0 = pix_bit;
				op.bits0 = (pixel_mode == pfb_pkg::PIX_SET) ? pix_bit : 8'h00;
				op.flip  = (pixel_mode == pfb_pkg::PIX_INVERT);
			end
			pfb_pkg::CMD_BLIT: begin
				op.err = blit_bad;
			end
			pfb_pkg::CMD_SRC: begin
				if (!active_q) begin
					op.err = 1'b1;
				end else begin
					op.kind  = pfb_pkg::OP_MERGE;
					op.addr0 = idx0[pfb_pkg::ADDR_W-1:0];
					op.addr1 = idx1[pfb_pkg::ADDR_W-1:0];
					op.en0   = ok0;
					op.en1   = spill_en && ok1;
					op.keep0 = low_wide[7:0];
					op.bits0 = bits_wide[7:0];
					op.keep1 = 8'((9'd1 << spill) - 9'd1);
					op.bits1 = 8'(block >> room);
					op.err   = !ok0 || (spill_en && !ok1);
					op.done  = row_end && (rows_left_q == {3'b000, n});
				end
			end
			pfb_pkg::CMD_READ: begin
				if ({2'b00, read_index} >= store_used) begin
					op.err = 1'b1;
				end else begin
					op.kind  = pfb_pkg::OP_READ;
					op.addr0 = read_index[pfb_pkg::ADDR_W-1:0];
				end
			end
			default: begin
				op.err = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			dest_page_q <= '0;
			dest_bit_q  <= '0;
			src_bit_q   <= '0;
			col_cnt_q   <= '0;
			rows_left_q <= '0;
			origin_q    <= '0;
			blit_cols_q <= '0;
		end else if (accept) begin
			if (opcode == pfb_pkg::CMD_BLIT) begin
				if (blit_bad) begin
					active_q <= 1'b0;
				end else begin
					active_q    <= 1'b1;
					origin_q    <= pos_x;
					blit_cols_q <= rect_width;
					col_cnt_q   <= '0;
					rows_left_q <= rect_height;
					dest_page_q <= {1'b0, pos_y[5:3]};
					dest_bit_q  <= pos_y[2:0];
					src_bit_q   <= src_row[2:0];
				end
			end else if (opcode == pfb_pkg::CMD_SRC && active_q) begin
				if (row_end) begin
					col_cnt_q   <= '0;
					rows_left_q <= rows_left_q - {3'b000, n};
					src_bit_q   <= '0;
					if (bit_sum >= 4'd8) begin
						dest_bit_q  <= 3'(bit_sum - 4'd8);
						dest_page_q <= dest_page_q + 4'd1;
					end else begin
						dest_bit_q <= bit_sum[2:0];
					end
					if (rows_left_q == {3'b000, n}) begin
						active_q <= 1'b0;
					end
				end else begin
					col_cnt_q <= cnt_next;
				end
			end
		end
	end

endmodule

@@ rtl/core/pfb_queue.sv @@
module pfb_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  pfb_pkg::op_t push_op,
	input  logic         pop,
	output pfb_pkg::op_t head,
	output logic         empty,
	output logic         full
);

	localparam int PTR_W = $clog2(pfb_pkg::QUEUE_DEPTH);

	pfb_pkg::op_t       slot_q [pfb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_W+1)'(pfb_pkg::QUEUE_DEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ rtl/core/pfb_back.sv @@
module pfb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  pfb_pkg::op_t          head,
	output logic                  pop,
	output pfb_pkg::back_status_t status,
	output logic                  strobe,
	output logic [7:0]            read_data,
	output logic                  error,
	output logic                  blit_done
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_MRG0,
		ST_MRG1,
		ST_READ
	} state_t;

	localparam logic [pfb_pkg::ADDR_W-1:0] LAST = pfb_pkg::ADDR_W'(pfb_pkg::STORE_BYTES - 1);

	state_t                     state_q;
	pfb_pkg::op_t               op_q;
	logic [pfb_pkg::ADDR_W-1:0] cnt_q;
	logic [7:0]                 mem [pfb_pkg::STORE_BYTES];
	logic [7:0]                 rdata_q;
	logic                       strobe_q;
	logic [7:0]                 data_q;
	logic                       err_q;
	logic                       done_q;

	logic                       we;
	logic [pfb_pkg::ADDR_W-1:0] waddr;
	logic [7:0]                 wdata;
	logic                       re;
	logic [pfb_pkg::ADDR_W-1:0] raddr;

	function automatic logic [7:0] merge(input logic [7:0] old, input logic [7:0] keep,
		input logic [7:0] bits, input logic flip);
		merge = flip ? (old ^ keep) : ((old & ~keep) | (bits & keep));
	endfunction

	assign pop                 = (state_q == ST_IDLE) && !empty;
	assign status.initializing = (state_q == ST_INIT);
	assign strobe              = strobe_q;
	assign read_data           = data_q;
	assign error               = err_q;
	assign blit_done           = done_q;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = 8'h00;
		re    = 1'b0;
		raddr = head.addr0;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				re = pop;
			end
			ST_MRG0: begin
				we    = op_q.en0;
				waddr = op_q.addr0;
				wdata = merge(rdata_q, op_q.keep0, op_q.bits0, op_q.flip);
				re    = op_q.en1;
				raddr = op_q.addr1;
			end
			ST_MRG1: begin
				we    = 1'b1;
				waddr = op_q.addr1;
				wdata = merge(rdata_q, op_q.keep1, op_q.bits1, 1'b0);
			end
			ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			cnt_q    <= '0;
			op_q     <= '0;
			strobe_q <= 1'b0;
			data_q   <= '0;
			err_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			data_q   <= '0;
			err_q    <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + pfb_pkg::ADDR_W'(1);
					if (cnt_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						op_q  <= head;
						cnt_q <= '0;
						unique case (head.kind)
							pfb_pkg::OP_CLEAR: state_q <= ST_CLR;
							pfb_pkg::OP_READ:  state_q <= ST_READ;
							pfb_pkg::OP_MERGE: state_q <= ST_MRG0;
							default: begin
								strobe_q <= 1'b1;
								err_q    <= head.err;
							end
						endcase
					end
				end
				ST_CLR: begin
					cnt_q <= cnt_q + pfb_pkg::ADDR_W'(1);
					if (cnt_q == LAST) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_MRG0: begin
					if (op_q.en1) begin
						state_q <= ST_MRG1;
					end else begin
						strobe_q <= 1'b1;
						err_q    <= op_q.err;
						done_q   <= op_q.done;
						state_q  <= ST_IDLE;
					end
				end
				ST_MRG1: begin
					strobe_q <= 1'b1;
					err_q    <= op_q.err;
					done_q   <= op_q.done;
					state_q  <= ST_IDLE;
				end
				ST_READ: begin
					strobe_q <= 1'b1;
					data_q   <= rdata_q;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/page_framebuffer_blitter.sv @@
// Monochrome page frame buffer with pixel operations and a streamed bit blit.
// Command channel: an item is taken at a rising edge with start high and busy
// low. Clear store, pixel op, blit start, blit source byte and read byte each
// give exactly one result, shown for one cycle with strobe high; the receiver
// cannot hold results off, so results leave as soon as they are ready.
// Configuration channel: cfg_valid/cfg_index/cfg_data, always ready; index 0
// is the width in use, index 1 the pages in use. Write only while idle.
// A store clear sweeps all 1024 bytes of the store. The store sequencer
// does one read-modify-write per destination byte. A two-entry queue lets
// the front end take commands while the sequencer works; busy rises when
// the queue is full.
// After reset the sequencer runs a clearing pass with busy high;
// configuration writes are taken during that pass.
module page_framebuffer_blitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] opcode,
	input  logic [6:0] pos_x,
	input  logic [5:0] pos_y,
	input  logic [1:0] pixel_mode,
	input  logic [5:0] src_row,
	input  logic [7:0] rect_width,
	input  logic [6:0] rect_height,
	input  logic [7:0] src_byte,
	input  logic [9:0] read_index,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       strobe,
	output logic [7:0] read_data,
	output logic       error,
	output logic       blit_done
);

	pfb_pkg::cfg_t         cfg_q;
	pfb_pkg::op_t          front_op;
	pfb_pkg::op_t          head;
	pfb_pkg::back_status_t back_status;
	logic                  accept;
	logic                  q_empty;
	logic                  q_full;
	logic                  pop;

	// A command transfer happens when start is high, the queue has a free slot
	// and the store is not being cleared after reset.
	assign busy      = q_full || back_status.initializing;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Display geometry registers. Writes beyond the two registers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= 8'(pfb_pkg::MAX_WIDTH);
			cfg_q.pages <= 4'(pfb_pkg::MAX_PAGES);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == pfb_pkg::CFG_WIDTH) begin
				cfg_q.width <= cfg_data;
			end else if (cfg_index == pfb_pkg::CFG_PAGES) begin
				cfg_q.pages <= cfg_data[3:0];
			end
		end
	end

	// The front end decodes each command, keeps the blit cursor and works out
	// the destination byte addresses and masks.
	pfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.opcode      (opcode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pixel_mode  (pixel_mode),
		.src_row     (src_row),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.src_byte    (src_byte),
		.read_index  (read_index),
		.cfg         (cfg_q),
		.op          (front_op)
	);

	pfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.push_op (front_op),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	// The back end owns the frame store and performs the reads, merges and
	// clearing sweeps in command order.
	pfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.status    (back_status),
		.strobe    (strobe),
		.read_data (read_data),
		.error     (error),
		.blit_done (blit_done)
	);

endmodule

@@ rtl/core/pfb_checker.sv @@
`include "page_framebuffer_blitter_macros.svh"

module pfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       strobe,
	input logic [7:0] read_data,
	input logic       error,
	input logic       blit_done
);

	`PFB_ASSERT_NOW(a_quiet_idle, clk, arst_n, !strobe, (read_data == 8'h00) && !error && !blit_done)
	`PFB_ASSERT_NOW(a_data_no_err, clk, arst_n, strobe && (read_data != 8'h00), !error && !blit_done)
	`PFB_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)
	`PFB_ASSERT_NEXT(a_reset_busy, clk, arst_n, $rose(arst_n), busy)

endmodule

bind page_framebuffer_blitter pfb_checker u_pfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.strobe    (strobe),
	.read_data (read_data),
	.error     (error),
	.blit_done (blit_done)
);

@@ bench/tb_page_framebuffer_blitter.sv @@
`timescale 1ns / 1ps

module tb_page_framebuffer_blitter;
	import pfb_pkg::*;

	// Opcodes above the read opcode have no meaning in the block and must be rejected.
	localparam logic [2:0] CMD_UNDEF = 3'd5;
	localparam int LIMIT = 600000;

	// One command transfer as the feeder presents it.
	typedef struct {
		logic [2:0] opcode;
		logic [6:0] pos_x;
		logic [5:0] pos_y;
		logic [1:0] pixel_mode;
		logic [5:0] src_row;
		logic [7:0] rect_width;
		logic [6:0] rect_height;
		logic [7:0] src_byte;
		logic [9:0] read_index;
	} cmd_t;

	// One result as the block should show it on the strobe.
	typedef struct {
		logic [7:0] read_data;
		logic       error;
		logic       blit_done;
	} answer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [2:0] opcode = CMD_CLEAR;
	logic [6:0] pos_x = '0;
	logic [5:0] pos_y = '0;
	logic [1:0] pixel_mode = PIX_CLEAR;
	logic [5:0] src_row = '0;
	logic [7:0] rect_width = '0;
	logic [6:0] rect_height = '0;
	logic [7:0] src_byte = '0;
	logic [9:0] read_index = '0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_WIDTH;
	logic [7:0] cfg_data = '0;
	logic       strobe;
	logic [7:0] read_data;
	logic       error;
	logic       blit_done;

	page_framebuffer_blitter uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .pixel_mode(pixel_mode),
		.src_row(src_row), .rect_width(rect_width), .rect_height(rect_height),
		.src_byte(src_byte), .read_index(read_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .read_data(read_data),
		.error(error), .blit_done(blit_done)
	);

	always #1 clk = ~clk;

	// Commands waiting to be driven, the one on the port, and the results still owed.
	cmd_t    pending_cmds[$];
	cmd_t    cur_cmd;
	answer_t owed_answers[$];
	bit      cur_taken = 1'b1;
	int      idle_pct = 36;
	int      mismatches = 0;
	int      cycles = 0;

	// Shadow of the frame store, the blit engine and the registers.
	logic [7:0] shadow_store[STORE_BYTES];
	int reg_width = 128, reg_pages = 8;
	bit blit_on = 1'b0;
	int cur_page = 0, cur_bit = 0, first_bit = 0, col_index = 0;
	int rows_remaining = 0, origin_col = 0, latched_cols = 0;

	// The register settings as seen by the stimulus generator.
	int gen_width = 128, gen_pages = 8;

	function automatic int cols_in_use();
		return reg_width > MAX_WIDTH ? MAX_WIDTH : reg_width;
	endfunction

	function automatic int pages_in_use();
		return reg_pages > MAX_PAGES ? MAX_PAGES : reg_pages;
	endfunction

	// Replaces the bits under keep in one store byte; reports false when the
	// byte lies outside the part of the store in use.
	function automatic bit merge_into_store(int col, int page, int keep, int bits);
		int idx;
		if (col >= cols_in_use() || page >= pages_in_use())
			return 1'b0;
		idx = col + page * cols_in_use();
		if (idx >= STORE_BYTES)
			return 1'b0;
		shadow_store[idx] = (shadow_store[idx] & ~keep[7:0]) | (bits[7:0] & keep[7:0]);
		return 1'b1;
	endfunction

	// Places one source byte of the active blit and advances the engine.
	function automatic bit place_source_byte(int sb, ref bit finished);
		int n, block, col, low_keep, spill;
		bit ok;
		ok = 1'b1;
		n = 8 - first_bit;
		if (n > rows_remaining)
			n = rows_remaining;
		block = (sb >> first_bit) & ((1 << n) - 1);
		col = origin_col + col_index;
		low_keep = (((1 << n) - 1) << cur_bit) & 8'hFF;
		if (!merge_into_store(col, cur_page, low_keep, (block << cur_bit) & 8'hFF))
			ok = 1'b0;
		// Rows that run past the bottom of the destination byte spill into the next page.
		if (n > 8 - cur_bit) begin
			spill = n - (8 - cur_bit);
			if (!merge_into_store(col, cur_page + 1, (1 << spill) - 1, block >> (8 - cur_bit)))
				ok = 1'b0;
		end
		col_index = (col_index + 1) & 8'hFF;
		if (col_index >= latched_cols) begin
			col_index = 0;
			cur_bit += n;
			if (cur_bit >= 8) begin
				cur_bit -= 8;
				cur_page = (cur_page + 1) & 4'hF;
			end
			rows_remaining -= n;
			first_bit = 0;
			if (rows_remaining == 0) begin
				blit_on = 1'b0;
				finished = 1'b1;
			end
		end
		return ok;
	endfunction

	// Works out the result of one accepted command and updates the shadow state.
	function automatic answer_t frame_store_answer(cmd_t c);
		answer_t a;
		int w, rows, idx, bitpos;
		bit finished;
		w = cols_in_use();
		rows = pages_in_use() * 8;
		a.read_data = '0;
		a.error = 1'b0;
		finished = 1'b0;
		case (c.opcode)
			CMD_CLEAR: begin
				foreach (shadow_store[i])
					shadow_store[i] = '0;
			end
			CMD_PIXEL: begin
				idx = int'(c.pos_x) + int'(c.pos_y >> 3) * w;
				bitpos = c.pos_y[2:0];
				if (c.pos_x >= w || c.pos_y >= rows || c.pixel_mode == PIX_BAD
						|| idx >= STORE_BYTES) begin
					a.error = 1'b1;
				end else if (c.pixel_mode == PIX_CLEAR) begin
					shadow_store[idx][bitpos] = 1'b0;
				end else if (c.pixel_mode == PIX_SET) begin
					shadow_store[idx][bitpos] = 1'b1;
				end else begin
					shadow_store[idx][bitpos] = ~shadow_store[idx][bitpos];
				end
			end
			CMD_BLIT: begin
				// A rejected start also cancels any blit in progress.
				if (c.rect_width == 0 || c.rect_height == 0
						|| int'(c.pos_x) + int'(c.rect_width) > w
						|| int'(c.pos_y) + int'(c.rect_height) > rows) begin
					a.error = 1'b1;
					blit_on = 1'b0;
				end else begin
					blit_on = 1'b1;
					origin_col = c.pos_x;
					latched_cols = c.rect_width;
					col_index = 0;
					rows_remaining = c.rect_height;
					cur_page = c.pos_y >> 3;
					cur_bit = c.pos_y[2:0];
					first_bit = c.src_row[2:0];
				end
			end
			CMD_SRC: begin
				if (!blit_on)
					a.error = 1'b1;
				else if (!place_source_byte(c.src_byte, finished))
					a.error = 1'b1;
			end
			CMD_READ: begin
				if (c.read_index >= w * pages_in_use() || c.read_index >= STORE_BYTES)
					a.error = 1'b1;
				else
					a.read_data = shadow_store[c.read_index];
			end
			default: a.error = 1'b1;
		endcase
		a.blit_done = finished;
		return a;
	endfunction

	// Driver: presents the next pending command at the falling edge, holding the
	// current one until a transfer has taken it.
	always @(negedge clk) begin
		if (arst_n && (!start || cur_taken)) begin
			if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				cur_cmd = pending_cmds.pop_front();
				cur_taken = 1'b0;
				opcode <= cur_cmd.opcode;
				pos_x <= cur_cmd.pos_x;
				pos_y <= cur_cmd.pos_y;
				pixel_mode <= cur_cmd.pixel_mode;
				src_row <= cur_cmd.src_row;
				rect_width <= cur_cmd.rect_width;
				rect_height <= cur_cmd.rect_height;
				src_byte <= cur_cmd.src_byte;
				read_index <= cur_cmd.read_index;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each strobed result against the oldest expectation, then
	// records the expectation of a command accepted at this edge. A result never
	// comes in the cycle of its own transfer, so this order is safe.
	always @(posedge clk) begin
		answer_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && strobe) begin
			if (owed_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: read_data %h error %b blit_done %b",
						read_data, error, blit_done);
			end else begin
				want = owed_answers.pop_front();
				if (read_data !== want.read_data || error !== want.error
						|| blit_done !== want.blit_done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b/%b, got %h/%b/%b",
							want.read_data, want.error, want.blit_done,
							read_data, error, blit_done);
				end
			end
		end
		if (arst_n && start && !busy && !cur_taken) begin
			owed_answers.push_back(frame_store_answer(cur_cmd));
			cur_taken = 1'b1;
		end
	end

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.opcode = 3'($urandom);
		c.pos_x = 7'($urandom);
		c.pos_y = 6'($urandom);
		c.pixel_mode = 2'($urandom);
		c.src_row = 6'($urandom);
		c.rect_width = 8'($urandom);
		c.rect_height = 7'($urandom);
		c.src_byte = 8'($urandom);
		c.read_index = 10'($urandom);
		return c;
	endfunction

	task automatic push_cmd(logic [2:0] op, int x, int y, int mode, int ri);
		cmd_t c;
		c = random_cmd();
		c.opcode = op;
		c.pos_x = 7'(x);
		c.pos_y = 6'(y);
		c.pixel_mode = 2'(mode);
		c.read_index = 10'(ri);
		pending_cmds.push_back(c);
	endtask

	// Queues a blit start and nbytes source bytes with random content.
	task automatic push_blit(int x, int y, int srow, int w, int h, int nbytes);
		cmd_t c;
		c = random_cmd();
		c.opcode = CMD_BLIT;
		c.pos_x = 7'(x);
		c.pos_y = 6'(y);
		c.src_row = 6'(srow);
		c.rect_width = 8'(w);
		c.rect_height = 7'(h);
		pending_cmds.push_back(c);
		repeat (nbytes) begin
			c = random_cmd();
			c.opcode = CMD_SRC;
			pending_cmds.push_back(c);
		end
	endtask

	// Source bytes a well-formed blit needs: one per column for every source page.
	function automatic int bytes_for_blit(int srow, int w, int h);
		int first_rows;
		first_rows = 8 - (srow & 7);
		if (first_rows > h)
			first_rows = h;
		return w * (1 + (h - first_rows + 7) / 8);
	endfunction

	// Fills one phase with random traffic; most of it is complete blits.
	task automatic fill_phase(int count);
		int w, rows, bw, bh, x, y, srow, n, pick;
		w = gen_width > MAX_WIDTH ? MAX_WIDTH : gen_width;
		rows = 8 * (gen_pages > MAX_PAGES ? MAX_PAGES : gen_pages);
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45 && w > 0 && rows > 0) begin
				bw = ($urandom_range(0, 11) == 0) ? $urandom_range(1, w)
					: $urandom_range(1, w < 6 ? w : 6);
				bh = ($urandom_range(0, 5) == 0) ? $urandom_range(1, rows)
					: $urandom_range(1, rows < 14 ? rows : 14);
				x = $urandom_range(0, w - bw);
				y = $urandom_range(0, rows - bh);
				srow = $urandom_range(0, 63);
				pick = bytes_for_blit(srow, bw, bh);
				// A few blits are cut short and left for the next start to replace.
				if ($urandom_range(0, 9) == 0)
					pick = $urandom_range(0, pick);
				push_blit(x, y, srow, bw, bh, pick);
				n += pick + 1;
			end else if (pick < 68) begin
				push_cmd(CMD_PIXEL, $urandom_range(0, w > 0 ? w + 3 : 127) & 7'h7F,
					$urandom_range(0, rows + 3) & 6'h3F,
					$urandom_range(0, 9) == 0 ? PIX_BAD : $urandom_range(0, 2), 0);
				n++;
			end else if (pick < 90) begin
				push_cmd(CMD_READ, 0, 0, 0,
					$urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
					: $urandom_range(0, w * rows / 8 > 0 ? w * rows / 8 - 1 : 0));
				n++;
			end else if (pick < 91) begin
				push_cmd(CMD_CLEAR, 0, 0, 0, 0);
				n++;
			end else begin
				pending_cmds.push_back(random_cmd());
				n++;
			end
		end
	endtask

	// Waits until every queued command has been transferred and answered.
	task automatic drain();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || start || owed_answers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 8'(value);
		do @(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_WIDTH) begin
			reg_width = value & 8'hFF;
			gen_width = reg_width;
		end else begin
			reg_pages = value & 4'hF;
			gen_pages = reg_pages;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Register settings per phase: extremes, values above the store size, and zero.
	int set_width[9] = '{128, 1, 255, 37, 0, 64, 128, 9, 200};
	int set_pages[9] = '{8, 1, 15, 3, 0, 8, 2, 8, 5};

	initial begin
		foreach (shadow_store[i])
			shadow_store[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening at the reset setting of 128 columns by 8 pages.
		push_cmd(CMD_CLEAR, 0, 0, 0, 0);
		push_cmd(CMD_PIXEL, 0, 0, PIX_SET, 0);
		push_cmd(CMD_PIXEL, 127, 63, PIX_SET, 0);
		push_cmd(CMD_PIXEL, 127, 63, PIX_INVERT, 0);
		push_cmd(CMD_PIXEL, 127, 62, PIX_INVERT, 0);
		push_cmd(CMD_PIXEL, 0, 0, PIX_CLEAR, 0);
		push_cmd(CMD_PIXEL, 5, 5, PIX_BAD, 0);
		push_cmd(CMD_READ, 0, 0, 0, 1023);
		push_cmd(CMD_READ, 0, 0, 0, 0);
		push_cmd(CMD_UNDEF, 0, 0, 0, 0);
		push_cmd(CMD_UNDEF + 3'd2, 0, 0, 0, 0);
		push_cmd(CMD_SRC, 0, 0, 0, 0);
		push_blit(0, 0, 0, 0, 4, 0);
		push_blit(120, 0, 0, 16, 4, 0);
		push_blit(0, 60, 0, 2, 8, 0);
		// A start that is replaced after one byte by one whose rows span two pages.
		push_blit(10, 10, 0, 3, 3, 1);
		push_blit(126, 6, 3, 2, 10, bytes_for_blit(3, 2, 10));
		push_cmd(CMD_READ, 0, 0, 0, 126);
		push_cmd(CMD_READ, 0, 0, 0, 127 + 128);
		// This blit is left open after three of its source bytes, so that the
		// random traffic that follows may continue or replace it.
		push_blit(100, 40, 0, 4, 20, 3);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			idle_pct = ph < 3 ? 36 : (ph < 6 ? 77 : 0);
			write_reg(CFG_WIDTH, set_width[ph]);
			write_reg(CFG_PAGES, set_pages[ph]);
			fill_phase(92);
			drain();
		end

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
